>>> sv/dbdf_pkg.sv
// Shared types and constants for the detection box decode and filter unit.
`timescale 1ns / 1ps
`default_nettype none
package dbdf_pkg;

  localparam int VALUE_W  = 32;
  localparam int SCORE_W  = 16;
  localparam int CLASS_W  = 10;
  localparam int POS_W    = 11;
  localparam int KEPT_W   = 21;
  localparam int PAD_W    = 13;
  localparam int SCALE_W  = 24;
  localparam int DIM_W    = 14;
  localparam int MAXB_W   = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_W    = 34;
  localparam int PROD_W   = NUM_W + SCALE_W;
  localparam int EDGE_W   = PROD_W - 17;
  localparam int GEOM_N   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_X           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_Y           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BOXES       = 3'd6;

  localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd16384;
  localparam logic [SCALE_W-1:0] RST_INV_SCALE       = 24'd65536;
  localparam logic [DIM_W-1:0]   RST_IMAGE_DIM       = 14'd640;
  localparam logic [MAXB_W-1:0]  RST_MAX_BOXES       = 20'd30000;

  // Row position of the first score (after cx, cy, w, h) and the saturated position.
  localparam logic [POS_W-1:0] POS_FIRST_SCORE = 11'd4;
  localparam logic [POS_W-1:0] POS_SAT         = 11'h7FF;

  // Edge slots: left, top, right, bottom.
  localparam int EDGE_L = 0;
  localparam int EDGE_T = 1;
  localparam int EDGE_R = 2;
  localparam int EDGE_B = 3;

  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [EDGE_W-1:0] edge_t;

  typedef struct packed {
    logic [SCORE_W-1:0] conf;
    logic [CLASS_W-1:0] cls;
  } tag_t;

endpackage
`default_nettype wire

>>> sv/detection_box_decode_filter_unit.sv
// Top level: streaming box decode, score filter, letterbox undo and clamp.
`timescale 1ns / 1ps
`default_nettype none
// One prediction value is taken per clock while in_stall is low; rows and
// frames are marked by row_end and frame_end. The score compare runs on every
// score value, and a kept row starts a three-stage decode pipe (numerator
// build, 34x25 multiply, round and clamp) that ends in the output register. The
// input never waits unless the output is held and all three decode stages are
// full. The user must write configuration through cfg_we/cfg_index/cfg_data
// only while no transaction is in flight; the block does not enforce this.
module detection_box_decode_filter_unit #(
  parameter int CLASS_LIMIT = 1024
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire [dbdf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [dbdf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire signed [dbdf_pkg::VALUE_W-1:0]   in_value,
  input  wire                                  in_row_end,
  input  wire                                  in_frame_end,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [30:0]                          out_left,
  output logic [30:0]                          out_top,
  output logic signed [31:0]                   out_right,
  output logic signed [31:0]                   out_bottom,
  output logic [dbdf_pkg::SCORE_W-1:0]         out_confidence,
  output logic [dbdf_pkg::CLASS_W-1:0]         out_class_label
);
  import dbdf_pkg::*;

  localparam logic [POS_W-1:0] POS_END = POS_W'(CLASS_LIMIT + 4);

  // configuration
  logic [SCORE_W-1:0] thr_r;
  logic [PAD_W-1:0]   pad_x_r, pad_y_r;
  logic [SCALE_W-1:0] inv_scale_r;
  logic [DIM_W-1:0]   img_w_r, img_h_r;
  logic [MAXB_W-1:0]  max_boxes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= RST_SCORE_THRESHOLD;
      pad_x_r     <= '0;
      pad_y_r     <= '0;
      inv_scale_r <= RST_INV_SCALE;
      img_w_r     <= RST_IMAGE_DIM;
      img_h_r     <= RST_IMAGE_DIM;
      max_boxes_r <= RST_MAX_BOXES;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCORE_THRESHOLD: thr_r       <= cfg_data[SCORE_W-1:0];
        REG_PAD_X:           pad_x_r     <= cfg_data[PAD_W-1:0];
        REG_PAD_Y:           pad_y_r     <= cfg_data[PAD_W-1:0];
        REG_INV_SCALE:       inv_scale_r <= cfg_data[SCALE_W-1:0];
        REG_IMAGE_WIDTH:     img_w_r     <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    img_h_r     <= cfg_data[DIM_W-1:0];
        REG_MAX_BOXES:       max_boxes_r <= cfg_data[MAXB_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe handshake
  logic a_v_r, b_v_r, o_v_r;
  logic a_rdy, b_rdy, o_rdy;
  logic acc;

  assign o_rdy    = !o_v_r || !out_stall;
  assign b_rdy    = !b_v_r || o_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_stall = !a_rdy;
  assign acc      = in_valid && a_rdy;

  // row state
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [VALUE_W-1:0] geom_r [GEOM_N];
  logic [VALUE_W-1:0] geom_nxt [GEOM_N];
  logic [SCORE_W-1:0] best_r, best_nxt;
  logic [CLASS_W-1:0] cls_r, cls_nxt;
  logic [KEPT_W-1:0]  kept_r, kept_nxt;
  logic               stop_r, stop_nxt;
  logic               emit;
  logic               rend;
  logic [SCORE_W-1:0] score;
  logic [POS_W-1:0]   cls_pos;

  assign rend    = in_row_end || in_frame_end;
  assign cls_pos = pos_r - POS_FIRST_SCORE;

  always_comb begin
    if (in_value < 0) begin
      score = '0;
    end else if (|in_value[VALUE_W-1:SCORE_W]) begin
      score = '1;
    end else begin
      score = in_value[SCORE_W-1:0];
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    geom_nxt = geom_r;
    best_nxt = best_r;
    cls_nxt  = cls_r;
    kept_nxt = kept_r;
    stop_nxt = stop_r;
    emit     = 1'b0;
    if (acc) begin
      if (!stop_r) begin
        if (pos_r < POS_FIRST_SCORE) begin
          geom_nxt[pos_r[1:0]] = in_value;
        end else if (pos_r < POS_END) begin
          if (pos_r == POS_FIRST_SCORE || score > best_r) begin
            best_nxt = score;
            cls_nxt  = cls_pos[CLASS_W-1:0];
          end
        end
        if (rend) begin
          if (pos_r >= POS_FIRST_SCORE && best_nxt >= thr_r) begin
            emit     = 1'b1;
            kept_nxt = kept_r + 1'b1;
            if (kept_nxt > {1'b0, max_boxes_r}) stop_nxt = 1'b1;
          end
          pos_nxt = '0;
        end else if (pos_r != POS_SAT) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      if (in_frame_end) begin
        kept_nxt = '0;
        stop_nxt = 1'b0;
        pos_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      best_r <= '0;
      cls_r  <= '0;
      kept_r <= '0;
      stop_r <= 1'b0;
      for (int i = 0; i < GEOM_N; i++) geom_r[i] <= '0;
    end else begin
      pos_r  <= pos_nxt;
      geom_r <= geom_nxt;
      best_r <= best_nxt;
      cls_r  <= cls_nxt;
      kept_r <= kept_nxt;
      stop_r <= stop_nxt;
    end
  end

  // stage A: edge numerators in Q.17 network pixels
  num_t a_num_r [GEOM_N];
  num_t a_num_nxt [GEOM_N];
  tag_t a_tag_r;
  num_t cx2, cy2, w_e, h_e, px, py;

  assign cx2 = num_t'($signed(geom_r[0])) <<< 1;
  assign cy2 = num_t'($signed(geom_r[1])) <<< 1;
  assign w_e = num_t'($signed(geom_r[2]));
  assign h_e = num_t'($signed(geom_r[3]));
  assign px  = $signed({{(NUM_W-PAD_W-17){1'b0}}, pad_x_r, 17'd0});
  assign py  = $signed({{(NUM_W-PAD_W-17){1'b0}}, pad_y_r, 17'd0});

  always_comb begin
    a_num_nxt[EDGE_L] = cx2 - w_e - px;
    a_num_nxt[EDGE_T] = cy2 - h_e - py;
    a_num_nxt[EDGE_R] = cx2 + w_e - px;
    a_num_nxt[EDGE_B] = cy2 + h_e - py;
  end

  // stage B: scale
  prod_t b_prod_r [GEOM_N];
  tag_t  b_tag_r;
  prod_t scale_e;

  assign scale_e = prod_t'($signed({1'b0, inv_scale_r}));

  // stage C: round, shift, clamp
  edge_t edge_v [GEOM_N];
  edge_t rl, bl, r_min, b_min;
  logic [30:0] l_c, t_c;
  logic signed [31:0] r_c, b_c;

  always_comb begin
    for (int i = 0; i < GEOM_N; i++) begin
      edge_v[i] = edge_t'((b_prod_r[i] + prod_t'(65536)) >>> 17);
    end
  end

  assign rl = edge_t'($signed({1'b0, img_w_r}) - 16'sd1) <<< 16;
  assign bl = edge_t'($signed({1'b0, img_h_r}) - 16'sd1) <<< 16;
  assign r_min = (edge_v[EDGE_R] < rl) ? edge_v[EDGE_R] : rl;
  assign b_min = (edge_v[EDGE_B] < bl) ? edge_v[EDGE_B] : bl;

  always_comb begin
    if (edge_v[EDGE_L][EDGE_W-1])          l_c = '0;
    else if (|edge_v[EDGE_L][EDGE_W-1:31]) l_c = '1;
    else                                   l_c = edge_v[EDGE_L][30:0];
    if (edge_v[EDGE_T][EDGE_W-1])          t_c = '0;
    else if (|edge_v[EDGE_T][EDGE_W-1:31]) t_c = '1;
    else                                   t_c = edge_v[EDGE_T][30:0];
    // the limits sit below 2^31, so only the low side can overflow
    if (r_min[EDGE_W-1] && !(&r_min[EDGE_W-1:31])) r_c = 32'sh8000_0000;
    else                                           r_c = r_min[31:0];
    if (b_min[EDGE_W-1] && !(&b_min[EDGE_W-1:31])) b_c = 32'sh8000_0000;
    else                                           b_c = b_min[31:0];
  end

  // pipe registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= emit;
      if (b_rdy) b_v_r <= a_v_r;
      if (o_rdy) o_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      a_num_r      <= a_num_nxt;
      a_tag_r.conf <= best_nxt;
      a_tag_r.cls  <= cls_nxt;
    end
    if (a_v_r && b_rdy) begin
      for (int i = 0; i < GEOM_N; i++) b_prod_r[i] <= prod_t'(a_num_r[i]) * scale_e;
      b_tag_r <= a_tag_r;
    end
    if (b_v_r && o_rdy) begin
      out_left        <= l_c;
      out_top         <= t_c;
      out_right       <= r_c;
      out_bottom      <= b_c;
      out_confidence  <= b_tag_r.conf;
      out_class_label <= b_tag_r.cls;
    end
  end

  assign out_valid = o_v_r;

endmodule
`default_nettype wire

>>> sv/dbdf_checker.sv
// Port-level checker for the detection box decode and filter unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module dbdf_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_stall,
  input wire                                out_valid,
  input wire                                out_stall,
  input wire [30:0]                         out_left,
  input wire [31:0]                         out_right,
  input wire [dbdf_pkg::SCORE_W-1:0]        out_confidence,
  input wire [dbdf_pkg::CLASS_W-1:0]        out_class_label
);
  import dbdf_pkg::*;

  // result register empties on reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input may only back up when a result is held at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with output free");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left) && $stable(out_right)
      && $stable(out_confidence) && $stable(out_class_label))
    else $error("held result changed");

  // a free output never forces the input to wait
  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

endmodule

bind detection_box_decode_filter_unit dbdf_checker u_dbdf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_left        (out_left),
  .out_right       (out_right),
  .out_confidence  (out_confidence),
  .out_class_label (out_class_label)
);
`default_nettype wire

>>> verif/detection_box_decode_filter_unit_checker.sv
// Checker for the box decode unit: predicts boxes from accepted values and compares them.
`timescale 1ns / 1ps
module detection_box_decode_filter_unit_checker #(
  parameter int CLASS_LIMIT = 1024
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire [dbdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [dbdf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                in_valid,
  input  wire                                in_stall,
  input  wire signed [dbdf_pkg::VALUE_W-1:0] in_value,
  input  wire                                in_row_end,
  input  wire                                in_frame_end,
  input  wire                                out_valid,
  input  wire                                out_stall,
  input  wire [30:0]                         out_left,
  input  wire [30:0]                         out_top,
  input  wire signed [31:0]                  out_right,
  input  wire signed [31:0]                  out_bottom,
  input  wire [dbdf_pkg::SCORE_W-1:0]        out_confidence,
  input  wire [dbdf_pkg::CLASS_W-1:0]        out_class_label,
  output int                                 box_errors,
  output int                                 boxes_owed
);
  import dbdf_pkg::*;

  typedef struct packed {
    logic [30:0]         left;
    logic [30:0]         top;
    logic signed [31:0]  right;
    logic signed [31:0]  bottom;
    logic [SCORE_W-1:0]  conf;
    logic [CLASS_W-1:0]  cls;
  } box_t;

  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  logic [SCORE_W-1:0] thr;
  logic [PAD_W-1:0]   pad_x;
  logic [PAD_W-1:0]   pad_y;
  logic [SCALE_W-1:0] inv_scale;
  logic [DIM_W-1:0]   img_w;
  logic [DIM_W-1:0]   img_h;
  logic [MAXB_W-1:0]  max_boxes;

  logic [POS_W-1:0]   row_pos;
  logic signed [31:0] geom [GEOM_N];
  logic [SCORE_W-1:0] best_score;
  logic [CLASS_W-1:0] best_class;
  logic [KEPT_W-1:0]  kept;
  logic               stopped;

  box_t owed_boxes[$];

  // Q.17 network-space edge times Q8.16 scale, rounded half up to Q16.16.
  function automatic longint unletterbox(longint num);
    longint prod;
    prod = num * longint'(inv_scale);
    return (prod + 64'sd65536) >>> 17;
  endfunction

  function automatic longint bound(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic decode_row_value(logic signed [31:0] v, logic row_end, logic frame_end);
    logic             closes;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] cls_idx;
    logic [SCORE_W-1:0] s;
    longint cx, cy, w, h, px, py, x1, y1, x2, y2, rl, bl, l, t, r, b;
    box_t bx;
    closes = row_end || frame_end;
    if (!stopped) begin
      p = row_pos;
      if (p < POS_FIRST_SCORE) begin
        geom[p[1:0]] = v;
      end else if (int'(p) - 4 < CLASS_LIMIT) begin
        cls_idx = p - POS_FIRST_SCORE;
        if (v < 0) s = '0;
        else if (v > 32'sd65535) s = '1;
        else s = v[SCORE_W-1:0];
        if (cls_idx == 0 || s > best_score) begin
          best_score = s;
          best_class = cls_idx[CLASS_W-1:0];
        end
      end
      if (closes) begin
        if (p >= POS_FIRST_SCORE && best_score >= thr) begin
          cx = geom[0];
          cy = geom[1];
          w  = geom[2];
          h  = geom[3];
          px = longint'(pad_x) * 131072;
          py = longint'(pad_y) * 131072;
          x1 = unletterbox(2 * cx - w - px);
          y1 = unletterbox(2 * cy - h - py);
          x2 = unletterbox(2 * cx + w - px);
          y2 = unletterbox(2 * cy + h - py);
          rl = (longint'(img_w) - 1) * 65536;
          bl = (longint'(img_h) - 1) * 65536;
          l  = bound(x1, 0, I32_MAX);
          t  = bound(y1, 0, I32_MAX);
          r  = bound((x2 < rl) ? x2 : rl, I32_MIN, I32_MAX);
          b  = bound((y2 < bl) ? y2 : bl, I32_MIN, I32_MAX);
          bx.left   = l[30:0];
          bx.top    = t[30:0];
          bx.right  = r[31:0];
          bx.bottom = b[31:0];
          bx.conf   = best_score;
          bx.cls    = best_class;
          owed_boxes = {owed_boxes, bx};
          kept = kept + 1'b1;
          if (kept > max_boxes) stopped = 1'b1;
        end
        row_pos = '0;
      end else if (row_pos != POS_SAT) begin
        row_pos = row_pos + 1'b1;
      end
    end
    if (frame_end) begin
      kept    = '0;
      stopped = 1'b0;
      row_pos = '0;
    end
  endtask

  task automatic check_box();
    box_t want;
    box_t got;
    got = '{out_left, out_top, out_right, out_bottom, out_confidence, out_class_label};
    if (owed_boxes.size() == 0) begin
      box_errors++;
      if (box_errors <= 10)
        $display("unexpected box: l=%h t=%h r=%h b=%h conf=%h cls=%0d",
                 got.left, got.top, got.right, got.bottom, got.conf, got.cls);
    end else begin
      want = owed_boxes.pop_front();
      if (got.left !== want.left || got.top !== want.top || got.right !== want.right ||
          got.bottom !== want.bottom || got.conf !== want.conf || got.cls !== want.cls) begin
        box_errors++;
        if (box_errors <= 10) begin
          $display("box mismatch: expected l=%h t=%h r=%h b=%h conf=%h cls=%0d",
                   want.left, want.top, want.right, want.bottom, want.conf, want.cls);
          $display("              actual   l=%h t=%h r=%h b=%h conf=%h cls=%0d",
                   got.left, got.top, got.right, got.bottom, got.conf, got.cls);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thr        = RST_SCORE_THRESHOLD;
      pad_x      = '0;
      pad_y      = '0;
      inv_scale  = RST_INV_SCALE;
      img_w      = RST_IMAGE_DIM;
      img_h      = RST_IMAGE_DIM;
      max_boxes  = RST_MAX_BOXES;
      row_pos    = '0;
      foreach (geom[i]) geom[i] = '0;
      best_score = '0;
      best_class = '0;
      kept       = '0;
      stopped    = 1'b0;
      owed_boxes.delete();
    end else begin
      if (out_valid && !out_stall) check_box();
      if (cfg_we) begin
        case (cfg_index)
          REG_SCORE_THRESHOLD: thr       = cfg_data[SCORE_W-1:0];
          REG_PAD_X:           pad_x     = cfg_data[PAD_W-1:0];
          REG_PAD_Y:           pad_y     = cfg_data[PAD_W-1:0];
          REG_INV_SCALE:       inv_scale = cfg_data[SCALE_W-1:0];
          REG_IMAGE_WIDTH:     img_w     = cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT:    img_h     = cfg_data[DIM_W-1:0];
          REG_MAX_BOXES:       max_boxes = cfg_data[MAXB_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_row_value(in_value, in_row_end, in_frame_end);
    end
    boxes_owed <= owed_boxes.size();
  end

endmodule

>>> verif/detection_box_decode_filter_unit_tb.sv
// Testbench top: stimulus, idling, watchdog and verdict for the box decode unit.
`timescale 1ns / 1ps
module detection_box_decode_filter_unit_tb;
  import dbdf_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 110;
  localparam int PHASES      = 7;
  localparam int WIDE_SCORES = 1100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [VALUE_W-1:0]    in_value = '0;
  logic                         in_row_end = 1'b0;
  logic                         in_frame_end = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [30:0]                  out_left;
  logic [30:0]                  out_top;
  logic signed [31:0]           out_right;
  logic signed [31:0]           out_bottom;
  logic [SCORE_W-1:0]           out_confidence;
  logic [CLASS_W-1:0]           out_class_label;

  int box_errors;
  int boxes_owed;
  int burst_left = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit stall_on = 1'b0;
  logic [SCORE_W-1:0]        score_floor = RST_SCORE_THRESHOLD;
  logic signed [VALUE_W-1:0] last_score = '0;

  always #5 clk = ~clk;

  detection_box_decode_filter_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_row_end      (in_row_end),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left        (out_left),
    .out_top         (out_top),
    .out_right       (out_right),
    .out_bottom      (out_bottom),
    .out_confidence  (out_confidence),
    .out_class_label (out_class_label)
  );

  detection_box_decode_filter_unit_checker box_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_row_end      (in_row_end),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left        (out_left),
    .out_top         (out_top),
    .out_right       (out_right),
    .out_bottom      (out_bottom),
    .out_confidence  (out_confidence),
    .out_class_label (out_class_label),
    .box_errors      (box_errors),
    .boxes_owed      (boxes_owed)
  );

  // Receiver: stalled runs always alternate with free runs, some of them long.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      if (stall_on) begin
        stall_on   = 1'b0;
        stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 8);
      end else begin
        stall_on   = 1'b1;
        stall_left = $urandom_range(1, 10);
      end
    end
    stall_left--;
    out_stall <= stall_on;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One transaction on the input channel; bursts with random gaps between them.
  task automatic push_value(logic signed [VALUE_W-1:0] v, logic re, logic fe);
    int pause;
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(100, 300);
      end else begin
        burst_left = $urandom_range(1, 20);
        pause = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_value     <= v;
    in_row_end   <= re;
    in_frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic signed [VALUE_W-1:0] make_coord(int i);
    logic [15:0] whole;
    if ($urandom_range(0, 7) == 0) return $urandom;
    whole = (i < 2) ? 16'($urandom_range(0, 900)) : 16'($urandom_range(0, 500));
    return {whole, 16'($urandom)};
  endfunction

  // Mostly well-formed rows (geometry then scores), some noise rows.
  task automatic send_frame();
    int rows, r, len, i;
    bit noisy, last, tail;
    logic signed [VALUE_W-1:0] v;
    logic re, fe;
    rows = $urandom_range(1, 6);
    for (r = 0; r < rows; r++) begin
      last  = (r == rows - 1);
      noisy = ($urandom_range(0, 9) == 0);
      if (noisy) len = $urandom_range(1, 9);
      else len = 4 + (($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6));
      for (i = 0; i < len; i++) begin
        tail = (i == len - 1);
        if (noisy) begin
          v = $urandom;
        end else if (i < 4) begin
          v = make_coord(i);
        end else begin
          case ($urandom_range(0, 19))
            0:       last_score = $urandom;
            1:       last_score = 32'hFFFF_FFFF - $urandom_range(0, 999);
            2:       last_score = 32'h0001_0000 + $urandom_range(0, 100000);
            3, 4:    ;
            5:       last_score = score_floor;
            6:       last_score = score_floor - 1;
            default: last_score = $urandom_range(0, 65535);
          endcase
          v = last_score;
        end
        if (tail) begin
          fe = last;
          re = !last || ($urandom_range(0, 3) != 0);
        end else if (noisy) begin
          re = ($urandom_range(0, 3) == 0);
          fe = ($urandom_range(0, 15) == 0);
        end else begin
          re = 1'b0;
          fe = 1'b0;
        end
        push_value(v, re, fe);
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // Drain outstanding boxes, then give the decode pipe time to go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (boxes_owed != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int ph, c;
    logic [CFG_DATA_W-1:0] thr_v, padx_v, pady_v, inv_v, w_v, h_v, maxb_v;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows under reset configuration.
    push_value(32'h0064_0000, 1'b0, 1'b0);
    push_value(32'h0050_0000, 1'b0, 1'b0);
    push_value(32'h0032_0000, 1'b0, 1'b0);
    push_value(32'h0028_0000, 1'b0, 1'b0);
    push_value(32'sd16383,    1'b0, 1'b0);
    push_value(32'sd16384,    1'b0, 1'b0);
    push_value(32'sd16384,    1'b1, 1'b0);
    // geometry extremes, negative and oversized scores
    push_value(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_value(32'h8000_0000, 1'b0, 1'b0);
    push_value(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_value(32'h8000_0000, 1'b0, 1'b0);
    push_value(-32'sd1,       1'b0, 1'b0);
    push_value(32'sd70000,    1'b1, 1'b0);
    // best score below threshold
    push_value(32'h0001_0000, 1'b0, 1'b0);
    push_value(32'h0001_0000, 1'b0, 1'b0);
    push_value(32'h0001_0000, 1'b0, 1'b0);
    push_value(32'h0001_0000, 1'b0, 1'b0);
    push_value(32'sd16383,    1'b1, 1'b0);
    // short row without scores
    push_value(32'h0005_0000, 1'b0, 1'b0);
    push_value(32'h0006_0000, 1'b0, 1'b0);
    push_value(32'h0007_0000, 1'b1, 1'b0);
    // oversized box, frame end without row end
    push_value(32'h0140_8000, 1'b0, 1'b0);
    push_value(32'h0140_8000, 1'b0, 1'b0);
    push_value(32'h02BC_0000, 1'b0, 1'b0);
    push_value(32'h02BC_0000, 1'b0, 1'b0);
    push_value(32'sd65535,    1'b0, 1'b1);

    for (ph = 1; ph <= PHASES; ph++) begin
      settle();
      case (ph)
        1: begin
          thr_v = '0; padx_v = '0; pady_v = '0; inv_v = '0;
          w_v = '0; h_v = '0; maxb_v = '0;
        end
        2: begin
          thr_v = 24'h00FFFF; padx_v = 24'h001FFF; pady_v = 24'h001FFF;
          inv_v = 24'hFFFFFF; w_v = 24'd16383; h_v = 24'd16383; maxb_v = 24'h0FFFFF;
        end
        5: begin
          thr_v  = CFG_DATA_W'($urandom);
          padx_v = CFG_DATA_W'($urandom);
          pady_v = CFG_DATA_W'($urandom);
          inv_v  = CFG_DATA_W'($urandom);
          w_v    = CFG_DATA_W'($urandom);
          h_v    = CFG_DATA_W'($urandom);
          maxb_v = CFG_DATA_W'($urandom);
        end
        7: begin
          thr_v = '0; padx_v = 24'h001FFF; pady_v = 24'h001FFF; inv_v = 24'd1;
          w_v = 24'd1; h_v = 24'd1; maxb_v = 24'd1;
        end
        default: begin
          thr_v  = CFG_DATA_W'($urandom_range(8000, 50000));
          padx_v = CFG_DATA_W'($urandom_range(0, 80));
          pady_v = CFG_DATA_W'($urandom_range(0, 80));
          inv_v  = CFG_DATA_W'($urandom_range(20000, 150000));
          w_v    = CFG_DATA_W'($urandom_range(1, 1500));
          h_v    = CFG_DATA_W'($urandom_range(1, 1500));
          maxb_v = (ph == 4) ? CFG_DATA_W'($urandom_range(1000, 1048575))
                             : CFG_DATA_W'($urandom_range(1, 3));
        end
      endcase
      write_reg(REG_SCORE_THRESHOLD, thr_v);
      write_reg(REG_PAD_X, padx_v);
      write_reg(REG_PAD_Y, pady_v);
      write_reg(REG_INV_SCALE, inv_v);
      write_reg(REG_IMAGE_WIDTH, w_v);
      write_reg(REG_IMAGE_HEIGHT, h_v);
      write_reg(REG_MAX_BOXES, maxb_v);
      if (ph == 5) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      cfg_we <= 1'b0;
      score_floor = thr_v[SCORE_W-1:0];

      // Very wide row: class 1023 wins, classes past the limit must be ignored.
      if (ph == 6) begin
        for (c = 0; c < 4; c++) push_value(make_coord(c), 1'b0, 1'b0);
        for (c = 0; c < WIDE_SCORES; c++)
          push_value((c == 1023) ? 32'sd60000 :
                     (c >= 1024) ? 32'sd65535 : 32'($urandom_range(0, 50000)),
                     c == WIDE_SCORES - 1, c == WIDE_SCORES - 1);
      end

      items_sent = 0;
      while (items_sent < PHASE_ITEMS) send_frame();
    end

    settle();
    if (box_errors == 0 && boxes_owed == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
